// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/md5_pkg.sv =====
// md5 package: initial chaining values, round tables and helpers
package md5_pkg;
	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam int unsigned BLOCK_BYTES = 64;

	function automatic logic [31:0] round_const(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
			6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
			6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	// message word index used in round r
	function automatic logic [3:0] word_pick(input logic [5:0] r);
		logic [3:0] i;
		i = r[3:0];
		case (r[5:4])
			2'd0: word_pick = i;
			2'd1: word_pick = 4'(5 * i + 1);
			2'd2: word_pick = 4'(3 * i + 5);
			default: word_pick = 4'(7 * i);
		endcase
	endfunction

	function automatic logic [4:0] rot_amount(input logic [5:0] r);
		logic [4:0] s;
		case ({r[5:4], r[1:0]})
			4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
			4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
			4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
		endcase
		return s;
	endfunction
endpackage

// ===== rtl/md5_message_digest.sv =====
// md5 digest top level: byte intake, padding sequencer and shared round unit
//
// channel  direction  transaction
// input    in         start & !busy : data_byte, has_byte, end_of_message
// result   out        digest_valid  : digest_word, word_number, final_word
//
// a byte that does not fill the block, and does not end the message, is taken without raising busy
// a byte that fills the block then holds busy while the shared unit runs the 64 rounds of the compression
// a final item pads up to 64 byte slots (one byte slot a cycle), writes the length,
// runs one or two compressions of 64 rounds each, then emits its four words in order
// reset (arst_n low) restores the initial chaining values and a zero byte count
// results cannot be stalled; each word shows for one cycle under digest_valid
`include "assert_macros.svh"
module md5_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        digest_valid,
	output logic [31:0] digest_word,
	output logic [1:0]  word_number,
	output logic        final_word
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ROUND = 3'd1; // compression of the block
	localparam logic [2:0] ST_PAD   = 3'd2; // write 0x80 and zeros
	localparam logic [2:0] ST_LEN   = 3'd3; // write length words
	localparam logic [2:0] ST_OUT   = 3'd4; // emit digest words

	logic [2:0]  state_q;
	logic [31:0] chain_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [63:0] count_q;
	logic [31:0] block_q [16];
	logic [5:0]  round_q;
	logic [5:0]  pos_q;      // padding byte slot
	logic        closing_q;  // compression belongs to the closing sequence
	logic        len_done_q; // length already written in this block
	logic [1:0]  out_q;

	// shared round unit
	logic [31:0] f_w, t_w, rot_w, new_b_w;
	logic [4:0]  s_w;
	always_comb begin
		case (round_q[5:4])
			2'd0: f_w = (b_q & c_q) | (~b_q & d_q);
			2'd1: f_w = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f_w = b_q ^ c_q ^ d_q;
			default: f_w = c_q ^ (b_q | ~d_q);
		endcase
		t_w = a_q + f_w + block_q[md5_pkg::word_pick(round_q)]
			+ md5_pkg::round_const(round_q);
		s_w = md5_pkg::rot_amount(round_q);
		rot_w = (t_w << s_w) | (t_w >> (6'd32 - {1'b0, s_w}));
		new_b_w = rot_w + b_q;
	end

	logic        take_w;
	logic [5:0]  bpos_w;
	assign take_w = start && !busy;
	assign bpos_w = count_q[5:0];
	assign busy = (state_q != ST_IDLE);

	// store a byte into the block at a slot
	function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] lane,
		input logic [7:0] v);
		logic [31:0] r;
		r = w;
		r[lane*8 +: 8] = v;
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (take_w && has_byte)
			block_q[bpos_w[5:2]] <= put_byte(block_q[bpos_w[5:2]], bpos_w[1:0], data_byte);
		else if (state_q == ST_PAD)
			block_q[pos_q[5:2]] <= put_byte(block_q[pos_q[5:2]], pos_q[1:0],
				(pos_q == bpos_w) ? 8'h80 : 8'h00);
		else if (state_q == ST_LEN) begin
			block_q[14] <= {count_q[28:0], 3'b000};
			block_q[15] <= count_q[60:29];
		end
		// a second closing block is all zeros before the length
		else if (state_q == ST_ROUND && round_q == 6'd63 && closing_q && !len_done_q)
			for (int i = 0; i < 14; i++) block_q[i] <= '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			chain_q[0] <= md5_pkg::IV_A;
			chain_q[1] <= md5_pkg::IV_B;
			chain_q[2] <= md5_pkg::IV_C;
			chain_q[3] <= md5_pkg::IV_D;
			count_q    <= '0;
			round_q    <= '0;
			pos_q      <= '0;
			closing_q  <= 1'b0;
			len_done_q <= 1'b0;
			out_q      <= '0;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take_w) begin
						closing_q  <= end_of_message;
						len_done_q <= 1'b0;
						if (has_byte)
							count_q <= count_q + 64'd1;
						a_q <= chain_q[0]; b_q <= chain_q[1];
						c_q <= chain_q[2]; d_q <= chain_q[3];
						round_q <= '0;
						if (has_byte && bpos_w == 6'd63)
							state_q <= ST_ROUND;
						else if (end_of_message) begin
							pos_q   <= has_byte ? bpos_w + 6'd1 : bpos_w;
							state_q <= ST_PAD;
						end
					end
				end
				ST_ROUND: begin
					a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= new_b_w;
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						chain_q[0] <= chain_q[0] + d_q;
						chain_q[1] <= chain_q[1] + new_b_w;
						chain_q[2] <= chain_q[2] + b_q;
						chain_q[3] <= chain_q[3] + c_q;
						if (!closing_q)
							state_q <= ST_IDLE;
						else if (len_done_q) begin
							out_q   <= '0;
							state_q <= ST_OUT;
						end else if (count_q[5:0] == 6'd0)
							// a byte just filled the block: pad a fresh one
							begin
								pos_q   <= '0;
								state_q <= ST_PAD;
							end
						else
							state_q <= ST_LEN;
					end
				end
				ST_PAD: begin
					pos_q <= pos_q + 6'd1;
					if (pos_q == 6'd63) begin
						if (bpos_w >= 6'd56) begin
							a_q <= chain_q[0]; b_q <= chain_q[1];
							c_q <= chain_q[2]; d_q <= chain_q[3];
							round_q <= '0;
							state_q <= ST_ROUND;
						end else
							state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					len_done_q <= 1'b1;
					a_q <= chain_q[0]; b_q <= chain_q[1];
					c_q <= chain_q[2]; d_q <= chain_q[3];
					round_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_OUT: begin
					out_q <= out_q + 2'd1;
					if (out_q == 2'd3) begin
						chain_q[0] <= md5_pkg::IV_A;
						chain_q[1] <= md5_pkg::IV_B;
						chain_q[2] <= md5_pkg::IV_C;
						chain_q[3] <= md5_pkg::IV_D;
						count_q    <= '0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign digest_valid = (state_q == ST_OUT);
	assign digest_word  = chain_q[out_q];
	assign word_number  = out_q;
	assign final_word   = digest_valid && (out_q == 2'd3);

	// digest words run in order; the length step starts a fresh compression
	`ASSERT_IMPLY(a_final_last, clk, arst_n, final_word, word_number == 2'd3)
	`ASSERT_NEXT(a_out_run, clk, arst_n, digest_valid && out_q != 2'd3, digest_valid)
	`ASSERT_NEXT(a_len_round, clk, arst_n, state_q == ST_LEN,
		state_q == ST_ROUND && round_q == 6'd0)
endmodule
